FILE: rtl/hxd_pkg.sv
// ============================================================================
// hxd_pkg
// Shared types, constants and character helpers for the hex text decoder.
// ============================================================================
package hxd_pkg;

    localparam int HEADER_LEN  = 23;
    localparam int COUNT_WIDTH = 32;
    localparam int DEPTH_WIDTH = 16;

    // Length of the fixed header text, and the bits needed to index it
    localparam int TEXT_LEN   = 23;
    localparam int TEXT_IDX_W = $clog2(TEXT_LEN);

    localparam logic [7:0] HDR_TEXT [TEXT_LEN] = '{
        8'h7C, 8'h20, 8'h68, 8'h65, 8'h78, 8'h74, 8'h6F, 8'h67,
        8'h67, 8'h6C, 8'h65, 8'h20, 8'h6F, 8'h75, 8'h74, 8'h70,
        8'h75, 8'h74, 8'h20, 8'h66, 8'h69, 8'h6C, 8'h65
    };

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_LBR   = 8'h5B;
    localparam logic [7:0] CH_RBR   = 8'h5D;

    // Configuration register indexes
    localparam logic REG_HDR_EN = 1'b0;

    typedef enum logic [1:0] {
        ST_GO      = 2'd0,
        ST_NOT_HEX = 2'd1,
        ST_FORMAT  = 2'd2,
        ST_DONE    = 2'd3
    } t_status;

    typedef struct packed {
        logic                   byte_valid;
        logic [7:0]             out_byte;
        t_status                status;
        logic [COUNT_WIDTH-1:0] error_index;
        logic [COUNT_WIDTH-1:0] error_line;
        logic [COUNT_WIDTH-1:0] error_column;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_digit(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.val = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.val = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.val = 4'(c - 8'h37);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

FILE: rtl/hex_text_stream_decoder_unit.sv
// ============================================================================
// hex_text_stream_decoder_unit
// Decodes a character stream of hex digit pairs into bytes, with comments,
// whitespace, optional header match and positioned error reports.
// ============================================================================
//  channel   direction  handshake             payload
//  input     in         i_valid / o_ready     i_char_code, i_end_marker
//  result    out        o_valid / i_ready     o_byte_valid, o_out_byte, o_status,
//                                             o_error_index/line/column
//  config    in (APB)   psel/penable/pready   paddr, pwdata, prdata
//
// One item per cycle sustained while the result side accepts; each item
// passes the input register, then the decode step writing the result register.
// Synchronous active-low reset clears the stream state and the header enable.
// o_ready drops only while both the input and result registers are full
// and the result is stalled; a stalled result holds in place.
// ============================================================================
module hex_text_stream_decoder_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [7:0]                      i_char_code,
    input  logic                            i_end_marker,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_byte_valid,
    output logic [7:0]                      o_out_byte,
    output logic [1:0]                      o_status,
    output logic [hxd_pkg::COUNT_WIDTH-1:0] o_error_index,
    output logic [hxd_pkg::COUNT_WIDTH-1:0] o_error_line,
    output logic [hxd_pkg::COUNT_WIDTH-1:0] o_error_column,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import hxd_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_end;
    logic       r_out_valid;
    t_result    r_res;
    logic       r_hdr_en;

    logic    step;
    t_result core_res;

    // advance the decode when an item is held and the result slot is free or draining
    assign step    = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_char <= i_char_code;
            r_in_end  <= i_end_marker;
        end
    end

    hxd_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_char         (r_in_char),
        .i_end          (r_in_end),
        .i_hdr_en       (r_hdr_en),
        .o_result       (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= core_res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_byte_valid   = r_res.byte_valid;
    assign o_out_byte     = r_res.out_byte;
    assign o_status       = r_res.status;
    assign o_error_index  = r_res.error_index;
    assign o_error_line   = r_res.error_line;
    assign o_error_column = r_res.error_column;

    // register index sits in paddr[2]; the low two bits are the byte offset
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_en <= 1'b0;
        end else if (psel && penable && pwrite && paddr[2] == REG_HDR_EN) begin
            r_hdr_en <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_HDR_EN) ? {31'd0, r_hdr_en} : 32'd0;

endmodule

FILE: rtl/hxd_core.sv
// ============================================================================
// hxd_core
// Stream state and per-character decode: nibble pairing, comments,
// position counters, header match and error detection.
// ============================================================================
module hxd_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_char,
    input  logic             i_end,
    input  logic             i_hdr_en,
    output hxd_pkg::t_result o_result
);
    import hxd_pkg::*;

    logic                   r_pending, n_pending;
    logic [3:0]             r_hi, n_hi;
    logic                   r_skip, n_skip;
    logic [DEPTH_WIDTH-1:0] r_depth, n_depth;
    logic [COUNT_WIDTH-1:0] r_index, n_index;
    logic [COUNT_WIDTH-1:0] r_line, n_line;
    logic [COUNT_WIDTH-1:0] r_col, n_col;
    logic                   r_abort, n_abort;

    t_hex    hx;
    logic    hdr_bad;
    logic    dec_err;
    logic    got;
    t_result res;

    assign hx = hex_digit(i_char);

    assign hdr_bad = i_hdr_en
                  && (r_index < COUNT_WIDTH'(HEADER_LEN))
                  && (r_index < COUNT_WIDTH'(TEXT_LEN))
                  && (HDR_TEXT[r_index[TEXT_IDX_W-1:0]] != i_char);

    always_comb begin
        n_pending = r_pending;
        n_hi      = r_hi;
        n_skip    = r_skip;
        n_depth   = r_depth;
        n_index   = r_index;
        n_line    = r_line;
        n_col     = r_col;
        n_abort   = r_abort;
        dec_err   = 1'b0;
        got       = 1'b0;

        res.byte_valid   = 1'b0;
        res.out_byte     = 8'd0;
        res.status       = ST_GO;
        res.error_index  = r_index;
        res.error_line   = r_line;
        res.error_column = r_col;

        if (i_end) begin
            if (r_abort) begin
                res.status = ST_GO;
            end else if (i_hdr_en && r_index < COUNT_WIDTH'(HEADER_LEN)) begin
                res.status = ST_NOT_HEX;
            end else begin
                res.status = ST_DONE;
            end
            n_pending = 1'b0;
            n_hi      = 4'd0;
            n_skip    = 1'b0;
            n_depth   = '0;
            n_index   = '0;
            n_line    = COUNT_WIDTH'(1);
            n_col     = '0;
            n_abort   = 1'b0;
        end else if (!r_abort) begin
            // positions move even on the character that fails
            if (i_char == CH_LF) begin
                n_line = (r_line == '1) ? r_line : r_line + 1'b1;
                n_col  = '0;
            end else begin
                n_col  = (r_col == '1) ? r_col : r_col + 1'b1;
            end

            if (hdr_bad) begin
                res.status = ST_NOT_HEX;
                n_abort    = 1'b1;
            end else begin
                if (r_pending) begin
                    if (!hx.ok) begin
                        dec_err = 1'b1;
                    end else begin
                        got       = 1'b1;
                        n_pending = 1'b0;
                    end
                end else if (r_skip && i_char != CH_LF) begin
                    n_skip = r_skip;
                end else if (i_char == CH_LF) begin
                    n_skip = 1'b0;
                end else if (i_char == CH_BAR) begin
                    n_skip = 1'b1;
                end else if (i_char == CH_LBR) begin
                    n_depth = (r_depth == '1) ? r_depth : r_depth + 1'b1;
                end else if (r_depth != '0 && i_char == CH_RBR) begin
                    n_depth = r_depth - 1'b1;
                end else if (r_depth != '0) begin
                    n_depth = r_depth;
                end else if (hx.ok) begin
                    n_hi      = hx.val;
                    n_pending = 1'b1;
                end else if (i_char == CH_SPACE || i_char == CH_CR || i_char == CH_TAB) begin
                    n_skip = r_skip;
                end else begin
                    dec_err = 1'b1;
                end

                if (dec_err) begin
                    res.status = ST_FORMAT;
                    n_abort    = 1'b1;
                end else begin
                    n_index = (r_index == '1) ? r_index : r_index + 1'b1;
                end
            end

            res.byte_valid   = got;
            res.out_byte     = got ? {r_hi, hx.val} : 8'd0;
            res.error_line   = n_line;
            res.error_column = n_col;
        end
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_hi      <= 4'd0;
            r_skip    <= 1'b0;
            r_depth   <= '0;
            r_index   <= '0;
            r_line    <= COUNT_WIDTH'(1);
            r_col     <= '0;
            r_abort   <= 1'b0;
        end else if (i_step) begin
            r_pending <= n_pending;
            r_hi      <= n_hi;
            r_skip    <= n_skip;
            r_depth   <= n_depth;
            r_index   <= n_index;
            r_line    <= n_line;
            r_col     <= n_col;
            r_abort   <= n_abort;
        end
    end

endmodule

FILE: tb/hex_text_stream_decoder_unit_test.sv
`timescale 1ns / 1ps
// ============================================================================
// hex_text_stream_decoder_unit_test
// Self-checking bench for the hex text decoder. A behavioral decoder built
// into the bench predicts each result from the characters it accepts.
// Directed streams cover digit pairs, comments, whitespace, the stream-end
// outcomes and header matching. A long result stall follows, then random
// streams, mostly well formed, with random idling on both channels. Results
// are compared field by field in order.
// ============================================================================
module hex_text_stream_decoder_unit_test;

    import hxd_pkg::*;

    localparam logic [2:0] HDR_EN_ADDR = 3'(4 * REG_HDR_EN);
    localparam int RANDOM_ITEMS = 1600;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_ready;
    logic [7:0]             i_char_code;
    logic                   i_end_marker;
    logic                   o_valid;
    logic                   i_ready;
    logic                   o_byte_valid;
    logic [7:0]             o_out_byte;
    logic [1:0]             o_status;
    logic [COUNT_WIDTH-1:0] o_error_index;
    logic [COUNT_WIDTH-1:0] o_error_line;
    logic [COUNT_WIDTH-1:0] o_error_column;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [2:0]             paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;

    hex_text_stream_decoder_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_char_code    (i_char_code),
        .i_end_marker   (i_end_marker),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_byte_valid   (o_byte_valid),
        .o_out_byte     (o_out_byte),
        .o_status       (o_status),
        .o_error_index  (o_error_index),
        .o_error_line   (o_error_line),
        .o_error_column (o_error_column),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Decoder state as the bench sees it
    logic                   header_on;
    logic                   nib_pending;
    logic [3:0]             nib_high;
    logic                   in_line_comment;
    logic [DEPTH_WIDTH-1:0] block_depth;
    logic [COUNT_WIDTH-1:0] char_count;
    logic [COUNT_WIDTH-1:0] line_count;
    logic [COUNT_WIDTH-1:0] col_count;
    logic                   aborted;

    t_result awaited_decodes[$];
    int      mismatches;
    int      items_sent;
    bit      source_idles;
    bit      sink_idles;
    int      hold_left;

    function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic void clear_stream();
        nib_pending     = 1'b0;
        nib_high        = 4'd0;
        in_line_comment = 1'b0;
        block_depth     = '0;
        char_count      = '0;
        line_count      = 1;
        col_count       = '0;
        aborted         = 1'b0;
    endfunction

    // Advance the decoder state by one item and return the result it yields
    function automatic t_result decode_step(input logic [7:0] c, input logic e);
        t_result                r;
        logic                   is_hex;
        logic [3:0]             hv;
        logic                   bad;
        logic [COUNT_WIDTH-1:0] idx;
        r      = '0;
        idx    = char_count;
        is_hex = 1'b1;
        hv     = 4'd0;
        bad    = 1'b0;
        if (c >= "0" && c <= "9") begin
            hv = 4'(c - "0");
        end else if (c >= "a" && c <= "f") begin
            hv = 4'(c - "a" + 10);
        end else if (c >= "A" && c <= "F") begin
            hv = 4'(c - "A" + 10);
        end else begin
            is_hex = 1'b0;
        end

        if (e) begin
            if (aborted) begin
                r.status = ST_GO;
            end else if (header_on && char_count < HEADER_LEN) begin
                r.status = ST_NOT_HEX;
            end else begin
                r.status = ST_DONE;
            end
            r.error_index  = char_count;
            r.error_line   = line_count;
            r.error_column = col_count;
            clear_stream();
            return r;
        end

        r.status = ST_GO;
        if (!aborted) begin
            if (c == CH_LF) begin
                line_count = bump(line_count);
                col_count  = '0;
            end else begin
                col_count = bump(col_count);
            end
            if (header_on && idx < HEADER_LEN && idx < TEXT_LEN && HDR_TEXT[idx] != c) begin
                r.status = ST_NOT_HEX;
                aborted  = 1'b1;
            end else begin
                if (nib_pending) begin
                    if (!is_hex) begin
                        bad = 1'b1;
                    end else begin
                        r.byte_valid = 1'b1;
                        r.out_byte   = {nib_high, hv};
                        nib_pending  = 1'b0;
                    end
                end else if (in_line_comment && c != CH_LF) begin
                    // still inside a line comment
                end else if (c == CH_LF) begin
                    in_line_comment = 1'b0;
                end else if (c == CH_BAR) begin
                    in_line_comment = 1'b1;
                end else if (c == CH_LBR) begin
                    if (block_depth != '1) block_depth = block_depth + 1'b1;
                end else if (block_depth != 0 && c == CH_RBR) begin
                    block_depth = block_depth - 1'b1;
                end else if (block_depth != 0) begin
                    // inside a block comment
                end else if (is_hex) begin
                    nib_high    = hv;
                    nib_pending = 1'b1;
                end else if (!(c == CH_SPACE || c == CH_CR || c == CH_TAB)) begin
                    bad = 1'b1;
                end
                if (bad) begin
                    r.status = ST_FORMAT;
                    aborted  = 1'b1;
                end else begin
                    char_count = bump(char_count);
                end
            end
        end
        r.error_index  = idx;
        r.error_line   = line_count;
        r.error_column = col_count;
        return r;
    endfunction

    function automatic void compare_field(input string what, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // Mostly short pauses, now and then a long one
    function automatic int pause_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (awaited_decodes.size() == 0) begin
                $display("%0t: result with none expected, status %0d byte %0h",
                         $time, o_status, o_out_byte);
                mismatches++;
            end else begin
                want = awaited_decodes.pop_front();
                compare_field("byte_valid", 32'(want.byte_valid), 32'(o_byte_valid));
                compare_field("out_byte", 32'(want.out_byte), 32'(o_out_byte));
                compare_field("status", 32'(want.status), 32'(o_status));
                compare_field("error_index", want.error_index, o_error_index);
                compare_field("error_line", want.error_line, o_error_line);
                compare_field("error_column", want.error_column, o_error_column);
            end
        end
    end

    // Result side: a requested hold-off first, then random stalls if enabled
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        i_ready    = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                i_ready <= 1'b0;
            end else if (hold_left > 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else begin
                i_ready <= 1'b1;
                if (sink_idles) stall_left = pause_cycles();
            end
        end
    end

    task automatic send_item(input logic [7:0] c, input logic e);
        int gap;
        gap = source_idles ? pause_cycles() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_char_code  <= c;
        i_end_marker <= e;
        do @(posedge i_clk); while (!o_ready);
        awaited_decodes.push_back(decode_step(c, e));
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    endtask

    task automatic send_end();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (awaited_decodes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= HDR_EN_ADDR;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write the header enable while idle and read it back
    task automatic set_header_check(input logic v);
        logic [31:0] rd;
        wait_drained();
        apb_access(1'b1, {31'd0, v}, rd);
        apb_access(1'b0, 32'd0, rd);
        compare_field("hdr_en", {31'd0, v}, rd);
        header_on = v;
    endtask

    function automatic logic [7:0] rand_hex();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10) return 8'("0" + v);
        return ($urandom_range(0, 1) != 0) ? 8'("a" + v - 10) : 8'("A" + v - 10);
    endfunction

    function automatic logic [7:0] rand_blank();
        case ($urandom_range(0, 3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    task automatic test_directed_streams();
        source_idles = 1'b0;
        sink_idles   = 1'b0;
        set_header_check(1'b0);
        // digit extremes, line comment, nested block comment, whitespace
        send_text("00 fF|x");
        send_item(CH_LF, 1'b0);
        send_text("[[Z]]A9");
        send_item(CH_TAB, 1'b0);
        send_item(CH_CR, 1'b0);
        send_item(8'hFF, 1'b1);
        // stray close bracket, then ignored characters until the end item
        send_text("]5");
        send_item(8'h00, 1'b1);
        // first digit not followed by a second one
        send_text("7G");
        send_end();
        // pending nibble dropped at the end item
        send_text("3");
        send_end();
        send_item(8'hFF, 1'b0);
        send_end();
        send_item(8'h00, 1'b0);
        send_end();
    endtask

    task automatic test_header_match();
        source_idles = 1'b0;
        sink_idles   = 1'b0;
        set_header_check(1'b1);
        // short stream, then a wrong first character
        send_text("|");
        send_end();
        send_text("X");
        send_end();
        for (int i = 0; i < TEXT_LEN; i++) send_item(HDR_TEXT[i], 1'b0);
        send_text("1e");
        send_end();
    endtask

    // Hold results off long enough that the block stalls its input
    task automatic test_result_backpressure();
        source_idles = 1'b0;
        sink_idles   = 1'b0;
        set_header_check(1'b0);
        hold_left = 300;
        repeat (40) send_item(rand_hex(), 1'b0);
        send_end();
    endtask

    task automatic send_random_stream();
        int         kind;
        int         len;
        int         bad_pos;
        int         depth;
        logic [7:0] c;
        source_idles = ($urandom_range(0, 3) != 0);
        sink_idles   = ($urandom_range(0, 3) != 0);
        if (header_on) begin
            kind    = $urandom_range(0, 19);
            bad_pos = (kind == 0) ? $urandom_range(0, TEXT_LEN - 1) : TEXT_LEN;
            len     = (kind == 1) ? $urandom_range(0, TEXT_LEN - 1) : TEXT_LEN;
            for (int i = 0; i < len; i++) begin
                c = HDR_TEXT[i];
                if (i == bad_pos) c = c ^ 8'($urandom_range(1, 255));
                send_item(c, 1'b0);
            end
            if (len < TEXT_LEN) begin
                send_end();
                return;
            end
        end
        repeat ($urandom_range(1, 24)) begin
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                send_item(rand_hex(), 1'b0);
                send_item(rand_hex(), 1'b0);
            end else if (kind < 60) begin
                send_item(rand_blank(), 1'b0);
            end else if (kind < 68) begin
                send_item(CH_BAR, 1'b0);
                repeat ($urandom_range(0, 6)) send_item(8'($urandom_range(0, 255)), 1'b0);
                send_item(CH_LF, 1'b0);
            end else if (kind < 78) begin
                depth = $urandom_range(1, 3);
                repeat (depth) send_item(CH_LBR, 1'b0);
                repeat ($urandom_range(0, 4)) send_item(8'($urandom_range(0, 255)), 1'b0);
                repeat (depth) send_item(CH_RBR, 1'b0);
            end else if (kind < 84) begin
                send_item(CH_LF, 1'b0);
            end else if (kind < 90) begin
                // broken pair
                send_item(rand_hex(), 1'b0);
                send_item(8'($urandom_range(0, 255)), 1'b0);
            end else if (kind < 95) begin
                send_item(8'($urandom_range(0, 255)), 1'b0);
            end else begin
                send_item(($urandom_range(0, 1) != 0) ? CH_RBR : CH_LBR, 1'b0);
            end
        end
        if ($urandom_range(0, 9) != 0) send_end();
    endtask

    task automatic test_random_streams();
        int stop_at;
        for (int phase = 0; phase < 6; phase++) begin
            set_header_check(phase[0]);
            stop_at = items_sent + RANDOM_ITEMS / 6;
            while (items_sent < stop_at) send_random_stream();
        end
        set_header_check(1'b0);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_char_code  = 8'd0;
        i_end_marker = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        mismatches   = 0;
        items_sent   = 0;
        source_idles = 1'b0;
        sink_idles   = 1'b0;
        hold_left    = 0;
        header_on    = 1'b0;
        clear_stream();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_streams();
        test_header_match();
        test_result_backpressure();
        test_random_streams();

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("hex_text_stream_decoder_unit verification clean");
        end else begin
            $display("hex_text_stream_decoder_unit verification failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("hex_text_stream_decoder_unit verification failed");
        $finish;
    end

endmodule

FILE: hex_text_stream_decoder_unit.f
rtl/hxd_pkg.sv
rtl/hxd_core.sv
rtl/hex_text_stream_decoder_unit.sv
tb/hex_text_stream_decoder_unit_test.sv
